// ===== rtl/block_buffer_cache_get_assert.svh =====
// ----------------------------------------------------------------------------
// Block buffer cache lookup - assertion macros
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_GET_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_GET_ASSERT_SVH

// same-cycle implication
`define BBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bbc assertion failed");

// next-cycle implication
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bbc assertion failed");

`endif

// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache lookup - package
// Sizes, slot entry layout, memory request types and scan helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

	localparam int SLOTS      = 32;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int POS_W      = $clog2(SLOTS + 1);
	localparam int DEV_W      = 8;
	localparam int BLK_W      = 32;
	localparam int REFS_W     = 8;
	localparam int SLOT_OUT_W = 5;

	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	typedef struct packed {
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  blk;
		logic [REFS_W-1:0] refs;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		entry_t            data;
	} wr_req_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	// scan order: last slot first, then slot 0 upward
	function automatic logic [SLOT_W-1:0] scan_slot(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] pm1;
		pm1 = pos - POS_W'(1);
		if (pos == '0)
			return SLOT_W'(SLOTS - 1);
		else
			return pm1[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W+SLOT_OUT_W-1:0] wide;
		wide = (SLOT_W + SLOT_OUT_W)'(idx);
		return wide[SLOT_OUT_W-1:0];
	endfunction

endpackage

// ===== rtl/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/bbc_store.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache lookup - slot store
// Slot RAM plus per-slot valid bits; an unwritten slot reads as all zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_store (
	input  logic             clk,
	input  logic             arst_n,
	input  bbc_pkg::rd_req_t rd,
	input  bbc_pkg::wr_req_t wr,
	output bbc_pkg::entry_t  ent
);
	import bbc_pkg::*;

	logic [SLOTS-1:0]   valid_q;
	logic               valid_s1;
	logic [ENTRY_W-1:0] rdata;

	bbc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (rd.en),
		.raddr(rd.addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (wr.en)
				valid_q[wr.addr] <= 1'b1;
			if (rd.en)
				valid_s1 <= valid_q[rd.addr];
		end
	end

	assign ent = valid_s1 ? entry_t'(rdata) : '0;

endmodule

// ===== rtl/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache lookup - scan control
// Sweeps the slots in scan order, tracks first match and first free slot,
// writes the slot back and loads the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bbc_pkg::DEV_W-1:0]        device_id,
	input  logic [bbc_pkg::BLK_W-1:0]        block_number,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bbc_pkg::SLOT_OUT_W-1:0]   slot,
	output logic                             hit,
	output logic                             none_free,
	output bbc_pkg::rd_req_t                 rd,
	output bbc_pkg::wr_req_t                 wr,
	input  bbc_pkg::entry_t                  ent
);
	import bbc_pkg::*;

	state_t             state_q;
	logic [POS_W-1:0]   pos_q;
	logic               rd_vld_s1;
	logic               last_s1;
	logic [SLOT_W-1:0]  idx_s1;
	logic               match_q;
	logic               free_q;
	logic [SLOT_W-1:0]  match_idx_q;
	logic [SLOT_W-1:0]  free_idx_q;
	logic [REFS_W-1:0]  match_refs_q;
	logic [DEV_W-1:0]   dev_q;
	logic [BLK_W-1:0]   blk_q;
	logic               out_valid_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic               hit_q;
	logic               none_free_q;

	logic               accept;
	logic               fire;
	logic               tag_eq;
	logic [REFS_W-1:0]  new_refs;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign fire      = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
	assign tag_eq    = (ent.dev == dev_q) && (ent.blk == blk_q);

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign hit       = hit_q;
	assign none_free = none_free_q;

	always_comb begin
		rd.en   = (state_q == ST_SCAN) && (pos_q != POS_W'(SLOTS));
		rd.addr = scan_slot(pos_q);
	end

	always_comb begin
		if (!match_q)
			new_refs = REFS_W'(1);
		else if (match_refs_q == REFS_MAX)
			new_refs = REFS_MAX;
		else
			new_refs = match_refs_q + REFS_W'(1);
		wr.en        = fire && (match_q || free_q);
		wr.addr      = match_q ? match_idx_q : free_idx_q;
		wr.data.dev  = dev_q;
		wr.data.blk  = blk_q;
		wr.data.refs = new_refs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			rd_vld_s1   <= 1'b0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd.en;
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q   <= '0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd.en)
						pos_q <= pos_q + POS_W'(1);
					if (rd_vld_s1) begin
						if (!match_q && tag_eq)
							match_q <= 1'b1;
						if (!free_q && ent.refs == '0)
							free_q <= 1'b1;
						if (last_s1)
							state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (fire)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			dev_q <= device_id;
			blk_q <= block_number;
		end
		if (rd.en) begin
			idx_s1  <= rd.addr;
			last_s1 <= (pos_q == POS_W'(SLOTS - 1));
		end
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (!match_q && tag_eq) begin
				match_idx_q  <= idx_s1;
				match_refs_q <= ent.refs;
			end
			if (!free_q && ent.refs == '0)
				free_idx_q <= idx_s1;
		end
		if (fire) begin
			if (match_q)
				slot_q <= slot_field(match_idx_q);
			else if (free_q)
				slot_q <= slot_field(free_idx_q);
			else
				slot_q <= '0;
			hit_q       <= match_q;
			none_free_q <= !match_q && !free_q;
		end
	end

endmodule

// ===== rtl/block_buffer_cache_get.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache lookup - top level
// Looks up a device/block pair in the slot cache; bumps the count on a hit,
// claims the first free slot on a miss, reports none_free otherwise.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+--------------------
//  in      | device_id[7:0], block_number[31:0]   | in_valid / in_ready
//  out     | slot[4:0], hit, none_free            | out_valid / out_ready
//
// One request is handled at a time: the slot RAM read port visits one slot
// per cycle during the scan, and the next accept waits until the write-back
// step has loaded the result.
// Reset clears the per-slot valid bits at once; no clearing pass is needed.
// A held result does not block the next accept; a second result waits in
// the write-back step until the first beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_buffer_cache_get (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bbc_pkg::DEV_W-1:0]      device_id,
	input  logic [bbc_pkg::BLK_W-1:0]      block_number,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bbc_pkg::SLOT_OUT_W-1:0] slot,
	output logic                           hit,
	output logic                           none_free
);
	import bbc_pkg::*;

	`include "block_buffer_cache_get_assert.svh"

	rd_req_t rd;
	wr_req_t wr;
	entry_t  ent;

	bbc_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.rd    (rd),
		.wr    (wr),
		.ent   (ent)
	);

	bbc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.device_id   (device_id),
		.block_number(block_number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.slot        (slot),
		.hit         (hit),
		.none_free   (none_free),
		.rd          (rd),
		.wr          (wr),
		.ent         (ent)
	);

	`BBC_ASSERT_NOW(a_hit_xor_full, clk, arst_n, out_valid, !(hit && none_free))
	`BBC_ASSERT_NOW(a_full_slot_zero, clk, arst_n, out_valid && none_free, slot == '0)
	`BBC_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`BBC_ASSERT_NOW(a_no_write_in_idle, clk, arst_n, in_ready, !wr.en && !rd.en)

endmodule

// ===== sim/bbc_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache lookup - result checker
// Watches the request and result channels, keeps its own copy of the slot
// tags and reference counts, predicts the slot/hit/none_free result of every
// accepted request and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_lookup_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [bbc_pkg::DEV_W-1:0]      device_id,
	input  logic [bbc_pkg::BLK_W-1:0]      block_number,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [bbc_pkg::SLOT_OUT_W-1:0] slot,
	input  logic                           hit,
	input  logic                           none_free,
	output int                             fails,
	output int                             pending
);

	import bbc_pkg::*;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic                  hit;
		logic                  none_free;
	} lookup_t;

	logic [DEV_W-1:0]  tag_dev [SLOTS];
	logic [BLK_W-1:0]  tag_blk [SLOTS];
	logic [REFS_W-1:0] ref_cnt [SLOTS];

	lookup_t lookup_results [$];
	int      mismatch_cnt = 0;

	assign fails = mismatch_cnt;

	function automatic lookup_t cache_lookup(input logic [DEV_W-1:0] dev,
			input logic [BLK_W-1:0] blk);
		lookup_t r;
		int      idx;
		r = '0;
		for (int pos = 0; pos < SLOTS; pos++) begin
			idx = (pos == 0) ? SLOTS - 1 : pos - 1;
			if (tag_dev[idx] == dev && tag_blk[idx] == blk) begin
				if (ref_cnt[idx] != REFS_MAX)
					ref_cnt[idx] = ref_cnt[idx] + REFS_W'(1);
				r.slot = idx[SLOT_OUT_W-1:0];
				r.hit  = 1'b1;
				return r;
			end
		end
		for (int pos = 0; pos < SLOTS; pos++) begin
			idx = (pos == 0) ? SLOTS - 1 : pos - 1;
			if (ref_cnt[idx] == '0) begin
				ref_cnt[idx] = REFS_W'(1);
				tag_dev[idx] = dev;
				tag_blk[idx] = blk;
				r.slot = idx[SLOT_OUT_W-1:0];
				return r;
			end
		end
		r.none_free = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				tag_dev[i] = '0;
				tag_blk[i] = '0;
				ref_cnt[i] = '0;
			end
			lookup_results.delete();
			pending <= 0;
		end else begin
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (lookup_results.size() == 0) begin
					$error("result beat with no request waiting: slot %0d hit %0b none_free %0b",
						slot, hit, none_free);
					mismatch_cnt++;
				end else begin
					want = lookup_results.pop_front();
					if (slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, slot);
						mismatch_cnt++;
					end
					if (hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, hit);
						mismatch_cnt++;
					end
					if (none_free !== want.none_free) begin
						$error("none_free: expected %0b, got %0b", want.none_free, none_free);
						mismatch_cnt++;
					end
				end
			end
			if (in_valid === 1'b1 && in_ready === 1'b1)
				lookup_results.push_back(cache_lookup(device_id, block_number));
			pending <= lookup_results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Block buffer cache lookup - testbench top
// Drives lookup requests (a directed opening, then a random mix of a hot tag,
// a tag pool, near misses, extremes and noise) with random idling on both
// channels, long receiver hold-offs and drain pauses; the checker predicts
// and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int POOL      = 48;
	localparam int RAND_REQS = 800;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           in_valid     = 1'b0;
	logic                           in_ready;
	logic [bbc_pkg::DEV_W-1:0]      device_id    = '0;
	logic [bbc_pkg::BLK_W-1:0]      block_number = '0;
	logic                           out_valid;
	logic                           out_ready    = 1'b0;
	logic [bbc_pkg::SLOT_OUT_W-1:0] slot;
	logic                           hit;
	logic                           none_free;
	int                             fails;
	int                             pending;

	logic [bbc_pkg::DEV_W-1:0] pool_dev [POOL];
	logic [bbc_pkg::BLK_W-1:0] pool_blk [POOL];
	int                        burst_left = 0;

	block_buffer_cache_get i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.device_id    (device_id),
		.block_number (block_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.hit          (hit),
		.none_free    (none_free)
	);

	bbc_lookup_checker i_lookup_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.device_id    (device_id),
		.block_number (block_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.hit          (hit),
		.none_free    (none_free),
		.fails        (fails),
		.pending      (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(12, 4);
		else
			return $urandom_range(60, 20);
	endfunction

	task automatic send(input logic [bbc_pkg::DEV_W-1:0] dev,
			input logic [bbc_pkg::BLK_W-1:0] blk);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = idle_len();
			if ($urandom_range(29) == 0)
				burst_left = $urandom_range(60, 20);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		device_id    <= dev;
		block_number <= blk;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// receiver: random stalls, quiet stretches, two long hold-offs
	initial begin : receiver
		int cyc;
		int hold;
		int stall;
		int run;
		cyc   = 0;
		hold  = 0;
		stall = 0;
		run   = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 3000 || cyc == 15000)
				hold = 400;
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (run > 0) begin
					run--;
				end else begin
					stall = idle_len();
					run = ($urandom_range(19) == 0) ? $urandom_range(300, 100)
						: $urandom_range(8, 0);
				end
			end
		end
	end

	initial begin : stimulus
		int                        pick;
		int                        idx;
		int                        bitpos;
		logic [bbc_pkg::DEV_W-1:0] d;
		logic [bbc_pkg::BLK_W-1:0] b;
		for (int i = 0; i < POOL; i++) begin
			pool_dev[i] = bbc_pkg::DEV_W'($urandom);
			pool_blk[i] = bbc_pkg::BLK_W'($urandom);
		end
		pool_dev[0] = '0;
		pool_blk[0] = '0;
		pool_dev[1] = '1;
		pool_blk[1] = '1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// untouched slots carry zero tags
		send(8'h00, 32'h0000_0000);
		send(8'h00, 32'h0000_0000);
		send(8'h00, 32'h0000_0001);
		send(8'h01, 32'h0000_0000);
		send(8'hFF, 32'hFFFF_FFFF);
		send(8'hFF, 32'h0000_0000);
		send(8'h00, 32'hFFFF_FFFF);
		send(8'h00, 32'h0000_0001);
		send(8'hFF, 32'hFFFF_FFFF);
		send(8'h00, 32'h0000_0000);
		send(8'h80, 32'h8000_0000);
		send(8'h7F, 32'h7FFF_FFFF);
		send(8'h80, 32'h8000_0000);
		send(8'h7F, 32'h7FFF_FFFE);
		drain();

		for (int n = 0; n < RAND_REQS; n++) begin
			if (n > 0 && n % 250 == 0)
				drain();
			pick = $urandom_range(99);
			if (pick < 35) begin
				d = pool_dev[0];
				b = pool_blk[0];
			end else if (pick < 75) begin
				idx = $urandom_range(POOL - 1);
				d = pool_dev[idx];
				b = pool_blk[idx];
			end else if (pick < 87) begin
				idx = $urandom_range(POOL - 1);
				d = pool_dev[idx];
				b = pool_blk[idx];
				bitpos = $urandom_range(bbc_pkg::DEV_W + bbc_pkg::BLK_W - 1);
				if (bitpos < bbc_pkg::DEV_W)
					d[bitpos] = ~d[bitpos];
				else
					b[bitpos - bbc_pkg::DEV_W] = ~b[bitpos - bbc_pkg::DEV_W];
			end else if (pick < 93) begin
				d = $urandom_range(1) ? '1 : '0;
				b = $urandom_range(1) ? '1 : '0;
			end else begin
				d = bbc_pkg::DEV_W'($urandom);
				b = bbc_pkg::BLK_W'($urandom);
			end
			send(d, b);
		end
		drain();
		repeat (2 * bbc_pkg::SLOTS + 8) @(posedge clk);

		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
